### design/great_circle_distance_check_unit_macros.svh
// ----------------------------------------------------------------------------
// great_circle_distance_check_unit_macros
// Assertion helpers for the distance check unit.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_CHECK_UNIT_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_CHECK_UNIT_MACROS_SVH

// clocked check, off while reset is held
`define GCDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check, also active during reset
`define GCDC_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/gcdc_pkg.sv
// ----------------------------------------------------------------------------
// gcdc_pkg
// Shared fixed-point types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcdc_pkg;

	// Q30 value with headroom for CORDIC growth
	typedef logic signed [32:0] q30_t;
	// vectoring datapath, wider for the CORDIC gain
	typedef logic signed [33:0] vec_t;

	localparam int RotSteps  = 30;
	localparam int VecSteps  = 30;
	localparam int SqrtSteps = 31;

	localparam q30_t CordicGain = 33'sd652032874;

	localparam logic [63:0] PiQ62     = 64'hC90FDAA22168C234;
	// microdegrees to radians, scaled by 2^54
	localparam logic [28:0] UdegToRad = 29'(PiQ62 / 64'd46080000000);

	// atan(2^-i) in Q30, rounded to nearest
	function automatic logic [29:0] atan_q30(input int unsigned i);
		logic [29:0] r;
		case (i)
			0:       r = 30'd843314857;
			1:       r = 30'd497837829;
			2:       r = 30'd263043837;
			3:       r = 30'd133525159;
			4:       r = 30'd67021687;
			5:       r = 30'd33543516;
			6:       r = 30'd16775851;
			7:       r = 30'd8388437;
			8:       r = 30'd4194283;
			9:       r = 30'd2097149;
			default: r = 30'd1 << (30 - i);
		endcase
		return r;
	endfunction

endpackage

### design/gcdc_rotate.sv
// ----------------------------------------------------------------------------
// gcdc_rotate
// Rotation CORDIC, one micro-rotation per pipeline stage; cos and sin in Q30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcdc_rotate (
	input  logic              clk,
	input  logic              en,
	input  logic [30:0]       angle,
	output gcdc_pkg::q30_t    cos_q30,
	output gcdc_pkg::q30_t    sin_q30
);
	import gcdc_pkg::*;

	q30_t x_s [RotSteps];
	q30_t y_s [RotSteps];
	q30_t z_s [RotSteps];

	for (genvar k = 0; k < RotSteps; k++) begin : g_step
		q30_t xi, yi, zi;
		q30_t at;

		if (k == 0) begin : g_first
			assign xi = CordicGain;
			assign yi = '0;
			assign zi = $signed({2'b00, angle});
		end else begin : g_next
			assign xi = x_s[k-1];
			assign yi = y_s[k-1];
			assign zi = z_s[k-1];
		end

		assign at = $signed({3'b000, atan_q30(k)});

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[32]) begin
					x_s[k] <= xi - (yi >>> k);
					y_s[k] <= yi + (xi >>> k);
					z_s[k] <= zi - at;
				end else begin
					x_s[k] <= xi + (yi >>> k);
					y_s[k] <= yi - (xi >>> k);
					z_s[k] <= zi + at;
				end
			end
		end
	end

	assign cos_q30 = x_s[RotSteps-1];
	assign sin_q30 = y_s[RotSteps-1];

endmodule

### design/gcdc_sqrt.sv
// ----------------------------------------------------------------------------
// gcdc_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcdc_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [60:0] radicand,
	output logic [30:0] root
);
	import gcdc_pkg::*;

	logic [61:0] n_s [SqrtSteps];
	logic [61:0] r_s [SqrtSteps];

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
		localparam logic [61:0] Bit = 62'd1 << (60 - 2 * k);
		logic [61:0] ni, ri, t;

		if (k == 0) begin : g_first
			assign ni = {1'b0, radicand};
			assign ri = '0;
		end else begin : g_next
			assign ni = n_s[k-1];
			assign ri = r_s[k-1];
		end

		assign t = ri + Bit;

		always_ff @(posedge clk) begin
			if (en) begin
				if (ni >= t) begin
					n_s[k] <= ni - t;
					r_s[k] <= (ri >> 1) + Bit;
				end else begin
					n_s[k] <= ni;
					r_s[k] <= ri >> 1;
				end
			end
		end
	end

	assign root = r_s[SqrtSteps-1][30:0];

endmodule

### design/gcdc_vector.sv
// ----------------------------------------------------------------------------
// gcdc_vector
// Vectoring CORDIC, one step per stage; returns atan2(y, x) in Q30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcdc_vector (
	input  logic            clk,
	input  logic            en,
	input  logic [30:0]     x_in,
	input  logic [30:0]     y_in,
	output gcdc_pkg::q30_t  angle
);
	import gcdc_pkg::*;

	vec_t x_s [VecSteps];
	vec_t y_s [VecSteps];
	q30_t z_s [VecSteps];

	for (genvar k = 0; k < VecSteps; k++) begin : g_step
		vec_t xi, yi;
		q30_t zi, at;

		if (k == 0) begin : g_first
			assign xi = $signed({3'b000, x_in});
			assign yi = $signed({3'b000, y_in});
			assign zi = '0;
		end else begin : g_next
			assign xi = x_s[k-1];
			assign yi = y_s[k-1];
			assign zi = z_s[k-1];
		end

		assign at = $signed({3'b000, atan_q30(k)});

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[33] && (yi != '0)) begin
					x_s[k] <= xi + (yi >>> k);
					y_s[k] <= yi - (xi >>> k);
					z_s[k] <= zi + at;
				end else begin
					x_s[k] <= xi - (yi >>> k);
					y_s[k] <= yi + (xi >>> k);
					z_s[k] <= zi - at;
				end
			end
		end
	end

	assign angle = z_s[VecSteps-1];

endmodule

### design/great_circle_distance_check_unit.sv
// ----------------------------------------------------------------------------
// great_circle_distance_check_unit
// Haversine distance between two positions, with an arrival radius check.
// ----------------------------------------------------------------------------
//  channel   | valid      | stall      | payload
//  ----------+------------+------------+-------------------------------------
//  position  | pos_valid  | pos_stall  | from/to lat/lon, microdegrees
//  distance  | dist_valid | dist_stall | distance_m, within_radius
//  config    | cfg_wr_en  | -          | cfg_wr_data (arrival radius, m)
//
//  One request per cycle while the result is not stalled; 99 register stages:
//  the 30-step rotation CORDIC, the 31-step square root, the 30-step
//  vectoring CORDIC and 8 other stages.
//  Reset clears the valid pipeline and sets the radius to 10 m.
//  A stalled result freezes the whole pipeline; pos_stall follows it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "great_circle_distance_check_unit_macros.svh"

module great_circle_distance_check_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [16:0]        cfg_wr_data,
	input  logic               pos_valid,
	output logic               pos_stall,
	input  logic signed [27:0] from_lat_udeg,
	input  logic signed [28:0] from_lon_udeg,
	input  logic signed [27:0] to_lat_udeg,
	input  logic signed [28:0] to_lon_udeg,
	output logic               dist_valid,
	input  logic               dist_stall,
	output logic [24:0]        distance_m,
	output logic               within_radius
);
	import gcdc_pkg::*;

	localparam int Lat = 8 + RotSteps + SqrtSteps + VecSteps;

	localparam logic signed [30:0] Udeg90  = 31'sd90000000;
	localparam logic signed [30:0] Udeg180 = 31'sd180000000;
	localparam logic signed [30:0] Udeg360 = 31'sd360000000;
	localparam logic [23:0]        TwoR    = 24'd12742000;
	localparam logic [24:0]        DistMax = 25'd20015087;
	localparam logic [30:0]        OneQ30  = 31'd1 << 30;

	function automatic logic [27:0] wrap_mag(input logic signed [30:0] d);
		logic signed [30:0] r;
		if (d >= Udeg180)
			r = d - Udeg360;
		else if (d < -Udeg180)
			r = d + Udeg360;
		else
			r = d;
		return r[30] ? 28'(-r) : r[27:0];
	endfunction

	logic        adv;
	logic [16:0] radius_q;
	logic [Lat-1:0] vld_q;

	assign pos_stall  = dist_valid & dist_stall;
	assign adv        = ~pos_stall;
	assign dist_valid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 17'd10;
			vld_q    <= '0;
		end else begin
			if (cfg_wr_en)
				radius_q <= cfg_wr_data;
			if (adv)
				vld_q <= {vld_q[Lat-2:0], pos_valid};
		end
	end

	// stage 1: differences, wrap and fold
	logic signed [30:0] dlat, dlon, lat1, lat2;
	logic [27:0] alat1, alat2;
	logic [27:0] hlat_s1, hlon_s1;
	logic [26:0] clat1_s1, clat2_s1;
	logic [1:0]  neg_s1;

	assign dlat = 31'(to_lat_udeg) - 31'(from_lat_udeg);
	assign dlon = 31'(to_lon_udeg) - 31'(from_lon_udeg);
	assign lat1 = 31'(from_lat_udeg);
	assign lat2 = 31'(to_lat_udeg);
	assign alat1 = wrap_mag(lat1);
	assign alat2 = wrap_mag(lat2);

	always_ff @(posedge clk) begin
		if (adv) begin
			hlat_s1 <= wrap_mag(dlat);
			hlon_s1 <= wrap_mag(dlon);
			// cos(180 - x) = -cos(x)
			if ($signed({3'b000, alat1}) > Udeg90) begin
				clat1_s1  <= 27'(Udeg180[27:0] - alat1);
				neg_s1[0] <= 1'b1;
			end else begin
				clat1_s1  <= alat1[26:0];
				neg_s1[0] <= 1'b0;
			end
			if ($signed({3'b000, alat2}) > Udeg90) begin
				clat2_s1  <= 27'(Udeg180[27:0] - alat2);
				neg_s1[1] <= 1'b1;
			end else begin
				clat2_s1  <= alat2[26:0];
				neg_s1[1] <= 1'b0;
			end
		end
	end

	// stage 2: scale to radians
	logic [56:0] hlat_s2, hlon_s2, clat1_s2, clat2_s2;
	logic [1:0]  neg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			hlat_s2  <= 57'(hlat_s1) * 57'(UdegToRad);
			hlon_s2  <= 57'(hlon_s1) * 57'(UdegToRad);
			clat1_s2 <= 57'(clat1_s1) * 57'(UdegToRad);
			clat2_s2 <= 57'(clat2_s1) * 57'(UdegToRad);
			neg_s2   <= neg_s1;
		end
	end

	// stage 3: round to Q30, half angles take one more shift
	logic [56:0] hlat_r, hlon_r, clat1_r, clat2_r;
	logic [30:0] hlat_s3, hlon_s3, clat1_s3, clat2_s3;
	logic [1:0]  neg_s3;

	assign hlat_r  = hlat_s2 + (57'd1 << 24);
	assign hlon_r  = hlon_s2 + (57'd1 << 24);
	assign clat1_r = clat1_s2 + (57'd1 << 23);
	assign clat2_r = clat2_s2 + (57'd1 << 23);

	always_ff @(posedge clk) begin
		if (adv) begin
			hlat_s3  <= hlat_r[55:25];
			hlon_s3  <= hlon_r[55:25];
			clat1_s3 <= clat1_r[54:24];
			clat2_s3 <= clat2_r[54:24];
			neg_s3   <= neg_s2;
		end
	end

	q30_t slat_sin, slon_sin, c1_cos, c2_cos;
	q30_t unused_c_lat, unused_c_lon, unused_s1, unused_s2;

	gcdc_rotate u_rot_hlat (.clk(clk), .en(adv), .angle(hlat_s3),
		.cos_q30(unused_c_lat), .sin_q30(slat_sin));
	gcdc_rotate u_rot_hlon (.clk(clk), .en(adv), .angle(hlon_s3),
		.cos_q30(unused_c_lon), .sin_q30(slon_sin));
	gcdc_rotate u_rot_lat1 (.clk(clk), .en(adv), .angle(clat1_s3),
		.cos_q30(c1_cos), .sin_q30(unused_s1));
	gcdc_rotate u_rot_lat2 (.clk(clk), .en(adv), .angle(clat2_s3),
		.cos_q30(c2_cos), .sin_q30(unused_s2));

	logic [RotSteps-1:0][1:0] neg_rot_s;

	always_ff @(posedge clk) begin
		if (adv)
			neg_rot_s <= {neg_rot_s[RotSteps-2:0], neg_s3};
	end

	// stage 4: squares and cos product
	q30_t c1n, c2n;
	logic signed [65:0] sq_lat_s4, sq_lon_s4, cc_s4;

	assign c1n = neg_rot_s[RotSteps-1][0] ? -c1_cos : c1_cos;
	assign c2n = neg_rot_s[RotSteps-1][1] ? -c2_cos : c2_cos;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_lat_s4 <= slat_sin * slat_sin;
			sq_lon_s4 <= slon_sin * slon_sin;
			cc_s4     <= c1n * c2n;
		end
	end

	// stage 5: cos product times lon term
	q30_t cc, slon;
	q30_t slat_s5;
	logic signed [65:0] prod_s5;

	assign cc   = $signed(cc_s4[62:30]);
	assign slon = $signed(sq_lon_s4[62:30]);

	always_ff @(posedge clk) begin
		if (adv) begin
			slat_s5 <= $signed(sq_lat_s4[62:30]);
			prod_s5 <= cc * slon;
		end
	end

	// stage 6: haversine term, clamped to [0, 1]
	logic signed [33:0] a_sum;
	logic [30:0] a_s6, am_s6;

	assign a_sum = 34'(slat_s5) + 34'($signed(prod_s5[62:30]));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (a_sum[33]) begin
				a_s6  <= '0;
				am_s6 <= OneQ30;
			end else if (a_sum > $signed({3'b000, OneQ30})) begin
				a_s6  <= OneQ30;
				am_s6 <= '0;
			end else begin
				a_s6  <= a_sum[30:0];
				am_s6 <= OneQ30 - a_sum[30:0];
			end
		end
	end

	logic [30:0] root_a, root_am;

	gcdc_sqrt u_sqrt_a (.clk(clk), .en(adv), .radicand({a_s6, 30'd0}), .root(root_a));
	gcdc_sqrt u_sqrt_am (.clk(clk), .en(adv), .radicand({am_s6, 30'd0}), .root(root_am));

	q30_t theta;

	gcdc_vector u_vec (.clk(clk), .en(adv), .x_in(root_am), .y_in(root_a), .angle(theta));

	// stage 7: distance in Q30 meters
	logic [31:0] theta_pos;
	logic [55:0] dq_s7;

	assign theta_pos = theta[32] ? 32'd0 : theta[31:0];

	always_ff @(posedge clk) begin
		if (adv)
			dq_s7 <= TwoR * theta_pos;
	end

	// stage 8: output register
	logic [24:0] dist_m_s8;
	logic        within_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_m_s8 <= (dq_s7[55:30] > 26'(DistMax)) ? DistMax : dq_s7[54:30];
			within_s8 <= dq_s7 <= {9'd0, radius_q, 30'd0};
		end
	end

	assign distance_m    = dist_m_s8;
	assign within_radius = within_s8;

	`GCDC_ASSERT(a_stall_holds, pos_stall |=> $stable(vld_q), "pipeline moved under stall")
	`GCDC_ASSERT(a_valid_source, $rose(dist_valid) |-> $past(vld_q[Lat-2]), "result from nowhere")
	`GCDC_ASSERT(a_dist_sat, dist_valid |-> distance_m <= DistMax, "distance above saturation")
	`GCDC_ASSERT_ANY(a_reset_empty, !arst_n |=> !dist_valid, "result valid in reset")

endmodule

### tb/gcdc_distance_checker.sv
// ----------------------------------------------------------------------------
// gcdc_distance_checker
// Watches the position and distance channels, computes the expected
// haversine distance and arrival flag for every accepted request, and
// compares each accepted result against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcdc_distance_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [16:0]        cfg_wr_data,
	input  logic               pos_valid,
	input  logic               pos_stall,
	input  logic signed [27:0] from_lat_udeg,
	input  logic signed [28:0] from_lon_udeg,
	input  logic signed [27:0] to_lat_udeg,
	input  logic signed [28:0] to_lon_udeg,
	input  logic               dist_valid,
	input  logic               dist_stall,
	input  logic [24:0]        distance_m,
	input  logic               within_radius,
	output int                 fail_count,
	output int                 pending_count,
	output int                 result_count
);

	localparam longint Deg360   = 64'sd360000000;
	localparam longint Deg180   = 64'sd180000000;
	localparam longint Deg90    = 64'sd90000000;
	localparam longint OneQ30   = 64'sd1 << 30;
	localparam longint EarthR   = 64'sd6371000;
	localparam longint DistSat  = 64'sd20015087;
	localparam longint GainQ30  = 64'sd652032874;
	localparam logic [63:0] PiQ62 = 64'hC90FDAA22168C234;
	localparam longint RadScale = longint'(PiQ62 / 64'd46080000000);

	typedef struct packed {
		logic [24:0] meters;
		logic        near;
	} dist_pred_t;

	dist_pred_t pending_dist[$];
	longint     atan_tbl[30];
	logic [16:0] radius_m;

	// floor shift for signed values
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint wrap_deg(longint d);
		longint r;
		r = d % Deg360;
		if (r >= Deg180) r = r - Deg360;
		if (r < -Deg180) r = r + Deg360;
		return r;
	endfunction

	function automatic longint udeg_to_q30(longint mag, int sh);
		logic [63:0] p;
		p = 64'(mag) * 64'(RadScale) + (64'd1 << (sh - 1));
		return longint'(p >> sh);
	endfunction

	function automatic void cordic_rotate(input longint ang, output longint cs,
			output longint sn);
		longint x, y, z, dx, dy;
		x = GainQ30;
		y = 0;
		z = ang;
		for (int i = 0; i < 30; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tbl[i];
			end else begin
				x += dx; y -= dy; z += atan_tbl[i];
			end
		end
		cs = x;
		sn = y;
	endfunction

	function automatic longint cordic_angle(longint x, longint y);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < 30; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += atan_tbl[i];
			end else begin
				x -= dx; y += dy; z -= atan_tbl[i];
			end
		end
		return z;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint half_sin_sq(longint delta);
		longint h, c, s;
		h = wrap_deg(delta);
		if (h < 0) h = -h;
		cordic_rotate(udeg_to_q30(h, 25), c, s);
		return floor_shr(s * s, 30);
	endfunction

	function automatic longint lat_cos(longint d);
		longint a, c, s;
		logic neg;
		a = wrap_deg(d);
		neg = 1'b0;
		if (a < 0) a = -a;
		if (a > Deg90) begin
			a = Deg180 - a;
			neg = 1'b1;
		end
		cordic_rotate(udeg_to_q30(a, 24), c, s);
		return neg ? -c : c;
	endfunction

	function automatic dist_pred_t haversine_dist(longint lat1, longint lon1,
			longint lat2, longint lon2, logic [16:0] radius);
		longint slat, slon, cc, a, theta;
		logic [63:0] y, x, dq, dm;
		dist_pred_t r;
		slat = half_sin_sq(lat2 - lat1);
		slon = half_sin_sq(lon2 - lon1);
		cc = floor_shr(lat_cos(lat1) * lat_cos(lat2), 30);
		a = slat + floor_shr(cc * slon, 30);
		if (a < 0) a = 0;
		if (a > OneQ30) a = OneQ30;
		y = int_sqrt(64'(a) << 30);
		x = int_sqrt(64'(OneQ30 - a) << 30);
		theta = cordic_angle(longint'(x), longint'(y));
		if (theta < 0) theta = 0;
		dq = 64'(EarthR) * (64'd2 * 64'(theta));
		dm = dq >> 30;
		if (dm > 64'(DistSat)) dm = 64'(DistSat);
		r.meters = dm[24:0];
		r.near = (dq <= (64'(radius) << 30));
		return r;
	endfunction

	initial begin
		longint acc, term;
		atan_tbl[0] = longint'(((PiQ62 >> 4) + (64'd1 << 29)) >> 30);
		for (int i = 1; i < 30; i++) begin
			acc = 0;
			for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
				term = longint'((64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1));
				acc += (k & 1) ? -term : term;
			end
			atan_tbl[i] = (acc + (64'sd1 << 29)) >>> 30;
		end
	end

	assign pending_count = pending_dist.size();

	always @(posedge clk or negedge arst_n) begin
		dist_pred_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			radius_m <= 17'd10;
			fail_count <= 0;
			result_count <= 0;
			pending_dist.delete();
		end else begin
			// predictions use the radius held when the request entered
			if (pos_valid && !pos_stall)
				pending_dist.push_back(haversine_dist(from_lat_udeg, from_lon_udeg,
					to_lat_udeg, to_lon_udeg, radius_m));
			if (dist_valid && !dist_stall) begin
				result_count <= result_count + 1;
				if (pending_dist.size() == 0) begin
					$error("unexpected result: distance_m %0d within_radius %0d",
						distance_m, within_radius);
					errs++;
				end else begin
					want = pending_dist.pop_front();
					if (distance_m !== want.meters) begin
						$error("distance_m: expected %0d actual %0d", want.meters,
							distance_m);
						errs++;
					end
					if (within_radius !== want.near) begin
						$error("within_radius: expected %0d actual %0d",
							want.near, within_radius);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			if (cfg_wr_en)
				radius_m <= cfg_wr_data;
		end
	end

endmodule

### tb/tb_great_circle_distance_check_unit.sv
// ----------------------------------------------------------------------------
// tb_great_circle_distance_check_unit
// Drives position requests through the distance unit under changing idle
// patterns and arrival radius settings; verdict taken from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_great_circle_distance_check_unit;

	localparam int PipeLat = 99;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [16:0]        cfg_wr_data;
	logic               pos_valid;
	logic               pos_stall;
	logic signed [27:0] from_lat_udeg;
	logic signed [28:0] from_lon_udeg;
	logic signed [27:0] to_lat_udeg;
	logic signed [28:0] to_lon_udeg;
	logic               dist_valid;
	logic               dist_stall;
	logic [24:0]        distance_m;
	logic               within_radius;
	int                 fail_count;
	int                 pending_count;
	int                 result_count;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 sent_count;

	great_circle_distance_check_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.pos_valid(pos_valid), .pos_stall(pos_stall),
		.from_lat_udeg(from_lat_udeg), .from_lon_udeg(from_lon_udeg),
		.to_lat_udeg(to_lat_udeg), .to_lon_udeg(to_lon_udeg),
		.dist_valid(dist_valid), .dist_stall(dist_stall),
		.distance_m(distance_m), .within_radius(within_radius)
	);

	gcdc_distance_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.pos_valid(pos_valid), .pos_stall(pos_stall),
		.from_lat_udeg(from_lat_udeg), .from_lon_udeg(from_lon_udeg),
		.to_lat_udeg(to_lat_udeg), .to_lon_udeg(to_lon_udeg),
		.dist_valid(dist_valid), .dist_stall(dist_stall),
		.distance_m(distance_m), .within_radius(within_radius),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		dist_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// one request, with random idle cycles ahead of it
	task automatic send_pos(input int la1, input int lo1, input int la2, input int lo2);
		while ($urandom_range(99) < send_idle_pct) begin
			pos_valid <= 1'b0;
			@(posedge clk);
		end
		pos_valid <= 1'b1;
		from_lat_udeg <= 28'(la1);
		from_lon_udeg <= 29'(lo1);
		to_lat_udeg <= 28'(la2);
		to_lon_udeg <= 29'(lo2);
		@(posedge clk);
		while (pos_stall) @(posedge clk);
		sent_count++;
	endtask

	task automatic set_radius(input logic [16:0] r);
		pos_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (PipeLat + 4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly realistic positions, some near-by pairs, some full-range noise
	task automatic send_random();
		int lat1, lon1, kind;
		kind = $urandom_range(9);
		lat1 = $urandom_range(180000000) - 90000000;
		lon1 = $urandom_range(360000000) - 180000000;
		if (kind < 4)
			send_pos(lat1, lon1, lat1 + int'($urandom_range(2000)) - 1000,
				lon1 + int'($urandom_range(2000)) - 1000);
		else if (kind < 8)
			send_pos(lat1, lon1, $urandom_range(180000000) - 90000000,
				$urandom_range(360000000) - 180000000);
		else
			send_pos($urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		logic [16:0] radius_set[6];
		radius_set = '{17'd0, 17'd100000, 17'd131071, 17'd1, 17'd5000, 17'd250};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		pos_valid = 1'b0;
		dist_stall = 1'b0;
		from_lat_udeg = '0;
		from_lon_udeg = '0;
		to_lat_udeg = '0;
		to_lon_udeg = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset radius, identical points, poles, antipodes, wrap, extremes
		send_pos(0, 0, 0, 0);
		send_pos(0, 0, 0, 5);
		send_pos(0, 0, 0, 100);
		send_pos(90000000, 0, -90000000, 0);
		send_pos(0, 0, 0, 180000000);
		send_pos(0, -180000000, 0, 180000000);
		send_pos(0, 179999999, 0, -179999999);
		send_pos(45000000, 10000000, 45000000, 10000000);
		send_pos(-90000000, -180000000, 90000000, 180000000);
		send_pos(28'sh7FFFFFF, 29'sh0FFFFFFF, 28'sh8000000, 29'sh10000000);
		send_pos(28'sh8000000, 29'sh10000000, 28'sh7FFFFFF, 29'sh0FFFFFFF);
		send_pos(28'sh7FFFFFF, 0, 0, 29'sh0FFFFFFF);
		send_pos(100000000, 200000000, -100000000, -200000000);
		send_pos(89999999, 0, 89999999, 180000000);
		send_pos(10000000, 20000000, -10000000, -160000000);
		send_pos(51500000, -100000, 51500090, -100000);
		send_pos(-33000000, 151000000, 40000000, -74000000);

		for (int p = 0; p < 6; p++) begin
			set_radius(radius_set[p]);
			send_idle_pct = (p < 2) ? 13 : (p < 4) ? 54 : 0;
			recv_idle_pct = (p < 2) ? 54 : (p < 4) ? 13 : 0;
			for (int n = 0; n < 305; n++) send_random();
			// a few short pairs on the equator, sized from the radius setting
			for (int n = 0; n < 5; n++)
				send_pos(0, 0, 0, int'($urandom_range(radius_set[p] / 111 + 3)));
		end
		pos_valid <= 1'b0;
		recv_idle_pct = 0;
		while (pending_count != 0) @(posedge clk);
		repeat (PipeLat + 10) @(posedge clk);
		$display("Sent %0d position requests, checked %0d distance results", sent_count,
			result_count);
		$display("over 7 arrival radius settings and three idle patterns");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
